// ===== rtl/range_max_sum_tree_defines.svh =====
// ----------------------------------------------------------------------------
// range_max_sum_tree_defines.svh
// Assertion macros shared by the range max/sum tree RTL.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SUM_TREE_DEFINES_SVH
`define RANGE_MAX_SUM_TREE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RMST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Types, sizes and the node combine function of the range max/sum tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int CAPACITY = 1024;
  localparam int NODE_CNT = 2 * CAPACITY;
  localparam int ADDR_W   = $clog2(NODE_CNT);
  localparam int IDX_W    = ADDR_W + 1;

  localparam int POS_W = 11;
  localparam int VAL_W = 32;
  localparam int SUM_W = 42;

  localparam logic [POS_W-1:0] LEN_RESET = POS_W'(1024);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] write_position;
    logic [VAL_W-1:0] write_value;
    logic [POS_W-1:0] query_left;
    logic [POS_W-1:0] query_right;
  } in_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] range_max;
    logic [SUM_W-1:0] range_sum;
    logic [SUM_W-1:0] even_sum;
  } out_rsp_t;

  typedef struct packed {
    logic [VAL_W-1:0] max_val;
    logic [SUM_W-1:0] sum_val;
    logic [SUM_W-1:0] even_val;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // Merge two subtrees: larger max, wrapping sums.
  function automatic node_t node_combine(node_t a, node_t b);
    node_t res;
    res.max_val  = (a.max_val > b.max_val) ? a.max_val : b.max_val;
    res.sum_val  = a.sum_val + b.sum_val;
    res.even_val = a.even_val + b.even_val;
    return res;
  endfunction

endpackage

// ===== rtl/rmst_ram.sv =====
// ----------------------------------------------------------------------------
// rmst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/range_max_sum_tree.sv =====
// ----------------------------------------------------------------------------
// range_max_sum_tree
// Segment tree over positions 1..active_length (at most CAPACITY) holding max, sum and
// even-position sum; point writes and range queries.
// ----------------------------------------------------------------------------
// After reset every node of the memory is swept to zero with in_ready low;
// configuration writes are taken throughout. All nodes sit in one memory with
// one read and one write port, and one combine unit (32-bit max, two 42-bit
// adds) serves both requests. A point write climbs one level of the tree per
// cycle, reading the sibling while the parent is written, and the next request
// is taken only after the walk ends at the root. A range query visits at most
// two nodes per level with one read each, plus a shift per level, so short or
// aligned ranges finish sooner. The result sits in an output register, so the
// next request is taken while a result waits; a second query holds in its
// final state until that earlier result is taken.
module range_max_sum_tree (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rmst_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rmst_pkg::out_rsp_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [rmst_pkg::POS_W-1:0] cfg_data
);

`include "range_max_sum_tree_defines.svh"

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_START = 7'b0000100,
    ST_UP    = 7'b0001000,
    ST_QUERY = 7'b0010000,
    ST_FLUSH = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [rmst_pkg::POS_W-1:0]  active_len_r;
  rmst_pkg::in_req_t           req_r;
  logic [rmst_pkg::ADDR_W-1:0] clr_r, clr_nxt;
  logic [rmst_pkg::ADDR_W-1:0] node_r, node_nxt;
  logic [rmst_pkg::IDX_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  rmst_pkg::node_t             cur_r, cur_nxt;
  rmst_pkg::node_t             acc_r, acc_nxt;
  logic                        pend_r, pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  rmst_pkg::out_rsp_t          out_data_r, out_data_nxt;

  // memory port
  logic                        wr_en;
  logic [rmst_pkg::ADDR_W-1:0] wr_addr;
  rmst_pkg::node_t             wr_data;
  logic [rmst_pkg::ADDR_W-1:0] rd_addr;
  rmst_pkg::node_t             rd_data;

  // shared combine unit
  rmst_pkg::node_t             cmb_a, cmb_res;

  logic [rmst_pkg::POS_W-1:0]  eff_len;
  logic [rmst_pkg::POS_W-1:0]  q_left, q_right;
  logic                        pos_ok;
  logic [rmst_pkg::ADDR_W-1:0] leaf, parent;
  logic [rmst_pkg::IDX_W-1:0]  hi_dec;
  rmst_pkg::node_t             leaf_node;

  rmst_ram #(
    .WIDTH (rmst_pkg::NODE_W),
    .DEPTH (rmst_pkg::NODE_CNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign eff_len = (32'(active_len_r) > rmst_pkg::CAPACITY) ?
                   rmst_pkg::POS_W'(rmst_pkg::CAPACITY) : active_len_r;
  assign q_left  = (req_r.query_left == '0) ? rmst_pkg::POS_W'(1) : req_r.query_left;
  assign q_right = (req_r.query_right > eff_len) ? eff_len : req_r.query_right;
  assign pos_ok  = (req_r.write_position != '0) && (req_r.write_position <= eff_len);
  assign leaf    = rmst_pkg::ADDR_W'(rmst_pkg::CAPACITY)
                 + rmst_pkg::ADDR_W'(req_r.write_position) - rmst_pkg::ADDR_W'(1);
  assign parent  = node_r >> 1;
  assign hi_dec  = hi_r - rmst_pkg::IDX_W'(1);

  always_comb begin
    leaf_node.max_val  = req_r.write_value;
    leaf_node.sum_val  = rmst_pkg::SUM_W'(req_r.write_value);
    leaf_node.even_val = req_r.write_position[0] ?
                         '0 : rmst_pkg::SUM_W'(req_r.write_value);
  end

  assign cmb_a   = (state_r == ST_UP) ? cur_r : acc_r;
  assign cmb_res = rmst_pkg::node_combine(cmb_a, rd_data);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = node_r;
    wr_data       = cmb_res;
    rd_addr       = node_r ^ rmst_pkg::ADDR_W'(1);

    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + rmst_pkg::ADDR_W'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (req_r.operation == rmst_pkg::OP_WRITE) begin
          if (pos_ok) begin
            // write the leaf and fetch its sibling
            wr_en     = 1'b1;
            wr_addr   = leaf;
            wr_data   = leaf_node;
            rd_addr   = leaf ^ rmst_pkg::ADDR_W'(1);
            cur_nxt   = leaf_node;
            node_nxt  = leaf;
            state_nxt = ST_UP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          acc_nxt = '0;
          if (q_left <= q_right) begin
            lo_nxt = rmst_pkg::IDX_W'(rmst_pkg::CAPACITY)
                   + rmst_pkg::IDX_W'(q_left) - rmst_pkg::IDX_W'(1);
            hi_nxt = rmst_pkg::IDX_W'(rmst_pkg::CAPACITY) + rmst_pkg::IDX_W'(q_right);
          end else begin
            lo_nxt = '0;
            hi_nxt = '0;
          end
          state_nxt = ST_QUERY;
        end
      end
      ST_UP: begin
        // sibling data is here: write the parent, fetch the next sibling
        wr_en    = 1'b1;
        wr_addr  = parent;
        wr_data  = cmb_res;
        cur_nxt  = cmb_res;
        node_nxt = parent;
        rd_addr  = parent ^ rmst_pkg::ADDR_W'(1);
        if (parent == rmst_pkg::ADDR_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (pend_r) begin
          acc_nxt = cmb_res;
        end
        if (lo_r < hi_r) begin
          if (lo_r[0]) begin
            rd_addr  = lo_r[rmst_pkg::ADDR_W-1:0];
            pend_nxt = 1'b1;
            lo_nxt   = lo_r + rmst_pkg::IDX_W'(1);
          end else if (hi_r[0]) begin
            rd_addr  = hi_dec[rmst_pkg::ADDR_W-1:0];
            pend_nxt = 1'b1;
            hi_nxt   = hi_dec;
          end else begin
            lo_nxt = lo_r >> 1;
            hi_nxt = hi_r >> 1;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_r) begin
          acc_nxt = cmb_res;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.range_max = acc_r.max_val;
          out_data_nxt.range_sum = acc_r.sum_val;
          out_data_nxt.even_sum  = acc_r.even_val;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      active_len_r <= rmst_pkg::LEN_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        active_len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    node_r     <= node_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  `RMST_ASSERT_NOW(a_clear_no_result, state_r == ST_CLEAR, !out_valid_r,
                   "result shown during clearing pass")
  `RMST_ASSERT_NEXT(a_write_no_result,
                    in_valid && in_ready && !out_valid_r &&
                    in_data.operation == rmst_pkg::OP_WRITE,
                    !out_valid_r, "point write produced a result")
  `RMST_ASSERT_NOW(a_query_bounds, state_r == ST_QUERY, lo_r <= hi_r,
                   "query walk crossed its bounds")
  `RMST_ASSERT_NOW(a_up_below_root, state_r == ST_UP, node_r > rmst_pkg::ADDR_W'(1),
                   "update walk passed the root")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives point writes and range queries into the range max/sum tree.
// A software copy of the stored values predicts each query's max, sum and
// even-position sum. Responses are compared field by field, in order.
// The length register is changed between phases with different idle and
// stall rates, and one long output stall backs up the input side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned POS_MAX        = (1 << rmst_pkg::POS_W) - 1;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // Flat copy of the position values; a query walks the clipped range directly.
  class range_tree_scoreboard;
    logic [rmst_pkg::VAL_W-1:0] stored_values [1:rmst_pkg::CAPACITY];
    logic [rmst_pkg::POS_W-1:0] active_length;
    rmst_pkg::out_rsp_t         expected_answers [$];
    int unsigned                failures;

    function new();
      foreach (stored_values[p]) stored_values[p] = '0;
      active_length = rmst_pkg::LEN_RESET;
      failures      = 0;
    endfunction

    function void set_length(logic [rmst_pkg::POS_W-1:0] len);
      active_length = len;
    endfunction

    function int unsigned span();
      return (active_length > rmst_pkg::CAPACITY) ? rmst_pkg::CAPACITY : active_length;
    endfunction

    function void note_request(rmst_pkg::in_req_t req);
      rmst_pkg::out_rsp_t ans;
      int unsigned        lo;
      int unsigned        hi;
      if (req.operation == rmst_pkg::OP_WRITE) begin
        if (req.write_position >= 1 && req.write_position <= span())
          stored_values[req.write_position] = req.write_value;
        return;
      end
      ans = '0;
      lo  = (req.query_left < 1) ? 1 : req.query_left;
      hi  = (req.query_right > span()) ? span() : req.query_right;
      for (int unsigned p = lo; p <= hi; p++) begin
        if (stored_values[p] > ans.range_max) ans.range_max = stored_values[p];
        ans.range_sum += stored_values[p];
        if (p % 2 == 0) ans.even_sum += stored_values[p];
      end
      expected_answers.push_back(ans);
    endfunction

    function void check_result(rmst_pkg::out_rsp_t got);
      rmst_pkg::out_rsp_t want;
      if (expected_answers.size() == 0) begin
        $error("response with no query outstanding: max %0d sum %0d even %0d",
               got.range_max, got.range_sum, got.even_sum);
        failures++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.range_max !== want.range_max) begin
        $error("range_max: expected %0d, got %0d", want.range_max, got.range_max);
        failures++;
      end
      if (got.range_sum !== want.range_sum) begin
        $error("range_sum: expected %0d, got %0d", want.range_sum, got.range_sum);
        failures++;
      end
      if (got.even_sum !== want.even_sum) begin
        $error("even_sum: expected %0d, got %0d", want.even_sum, got.even_sum);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_answers.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  rmst_pkg::in_req_t          in_data;
  logic                       out_valid;
  logic                       out_ready;
  rmst_pkg::out_rsp_t         out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [rmst_pkg::POS_W-1:0] cfg_data;

  range_tree_scoreboard board = new();

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  bit          pressure_req;
  int unsigned idle_cycles;

  range_max_sum_tree dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rmst_pkg::in_req_t make_write(int unsigned pos,
                                                   logic [rmst_pkg::VAL_W-1:0] val);
    rmst_pkg::in_req_t req;
    req                = '0;
    req.operation      = rmst_pkg::OP_WRITE;
    req.write_position = rmst_pkg::POS_W'(pos);
    req.write_value    = val;
    return req;
  endfunction

  function automatic rmst_pkg::in_req_t make_query(int unsigned left, int unsigned right);
    rmst_pkg::in_req_t req;
    req             = '0;
    req.operation   = rmst_pkg::OP_QUERY;
    req.query_left  = rmst_pkg::POS_W'(left);
    req.query_right = rmst_pkg::POS_W'(right);
    return req;
  endfunction

  // Mostly in-range positions and ranges; the rest spans the whole field.
  function automatic rmst_pkg::in_req_t random_request(int unsigned span,
                                                       int unsigned query_pct);
    rmst_pkg::in_req_t req;
    int unsigned       pick;
    int unsigned       lo;
    req.operation = ($urandom_range(99) < query_pct) ? rmst_pkg::OP_QUERY
                                                     : rmst_pkg::OP_WRITE;
    pick = $urandom_range(9);
    if (span > 0 && pick < 8) req.write_position = rmst_pkg::POS_W'($urandom_range(span, 1));
    else req.write_position = rmst_pkg::POS_W'($urandom_range(POS_MAX, 0));
    case ($urandom_range(5))
      0: req.write_value = '0;
      1: req.write_value = '1;
      2: req.write_value = rmst_pkg::VAL_W'($urandom_range(15));
      default: req.write_value = $urandom();
    endcase
    pick = $urandom_range(9);
    if (span > 0 && pick < 7) begin
      lo = $urandom_range(span, 1);
      req.query_left  = rmst_pkg::POS_W'(lo);
      req.query_right = rmst_pkg::POS_W'((pick == 0) ? lo : $urandom_range(span, lo));
    end else if (pick < 8) begin
      req.query_left  = rmst_pkg::POS_W'($urandom_range(1) ? 0 : $urandom_range(POS_MAX, 0));
      req.query_right = rmst_pkg::POS_W'(POS_MAX);
    end else begin
      req.query_left  = rmst_pkg::POS_W'($urandom_range(POS_MAX, 0));
      req.query_right = rmst_pkg::POS_W'($urandom_range(POS_MAX, 0));
    end
    return req;
  endfunction

  // Hold the request until the block takes it; valid stays high on return.
  task automatic send_request(rmst_pkg::in_req_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    board.note_request(req);
  endtask

  task automatic sender_gap();
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_length(int unsigned len);
    cfg_valid <= 1'b1;
    cfg_data  <= rmst_pkg::POS_W'(len);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_length(rmst_pkg::POS_W'(len));
  endtask

  // Wait for every response, then let a trailing write finish its walk.
  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned len, int unsigned send_idle, int unsigned recv_stall,
                           int unsigned count, int unsigned query_pct, bit squeeze);
    drain();
    write_length(len);
    sender_idle_pct    = send_idle;
    receiver_stall_pct = recv_stall;
    if (squeeze) pressure_req = 1'b1;
    repeat (count) begin
      send_request(random_request(board.span(), query_pct));
      sender_gap();
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: take responses, stall at random, and hold off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_result(out_data);
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog: end the run after a long stretch with no handshake at all.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    out_ready          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_data           = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    pressure_req       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset length.
    send_request(make_query(1, rmst_pkg::CAPACITY));
    send_request(make_write(1, '1));
    send_request(make_write(rmst_pkg::CAPACITY, '1));
    send_request(make_write(2, 32'h1234_5678));
    send_request(make_write(513, '0));
    send_request(make_write(0, 32'd7));
    send_request(make_write(POS_MAX, 32'd9));
    send_request(make_query(0, POS_MAX));
    send_request(make_query(2, 2));
    send_request(make_query(1, 1));
    send_request(make_query(rmst_pkg::CAPACITY, rmst_pkg::CAPACITY));
    send_request(make_query(5, 3));
    send_request(make_query(rmst_pkg::CAPACITY + 1, POS_MAX));
    send_request(make_query(0, 0));
    send_request(make_write(3, '1));
    send_request(make_query(1, 3));
    send_request(make_write(1, '0));
    send_request(make_write(rmst_pkg::CAPACITY - 1, 32'h8000_0001));
    send_request(make_query(1, rmst_pkg::CAPACITY));
    send_request(make_query(rmst_pkg::CAPACITY - 1, rmst_pkg::CAPACITY));
    in_valid <= 1'b0;

    run_phase(rmst_pkg::CAPACITY, 0, 0, 120, 50, 1'b0);
    run_phase(37, 78, 0, 100, 50, 1'b0);
    run_phase(1, 0, 78, 60, 50, 1'b0);
    run_phase(0, 10, 10, 40, 50, 1'b0);
    run_phase(POS_MAX, 10, 10, 120, 50, 1'b0);
    run_phase(600, 0, 0, 100, 70, 1'b1);
    run_phase(rmst_pkg::CAPACITY, 0, 78, 130, 50, 1'b0);
    run_phase($urandom_range(rmst_pkg::CAPACITY - 1, 2), 78, 0, 130, 50, 1'b0);

    drain();
    if (board.failures == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
